### src/windowed_transfer_splitter_assert.svh
// Assertion macros for the windowed transfer splitter.
// Depends on nothing; the macros expand to nothing in synthesis builds.
`ifndef WINDOWED_TRANSFER_SPLITTER_ASSERT_SVH
`define WINDOWED_TRANSFER_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define WTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Antecedent implies consequent in the next cycle.
`define WTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define WTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/wts_pkg.sv
// Package for the windowed transfer splitter: request and chunk types,
// memory range table and sizing constants. Depends on nothing.
`timescale 1ns / 1ps

package wts_pkg;

	localparam int ADDR_W = 32;
	localparam int CNT_W = 15;
	localparam int WIN_BITS = 16;
	localparam int REM_W = 9;
	localparam int BLKCNT_W = 8;

	localparam int MAX_TRANSFER_BYTES_DEF = 16384;
	localparam int MAX_BLOCK_COUNT_DEF = 128;

	// Block sizes as shifts: 512 bytes for chip memory, 8 bytes otherwise.
	localparam int BLK_SHIFT_MEM = 9;
	localparam int BLK_SHIFT_REG = 3;
	localparam int BLK_SIZE_MEM = 1 << BLK_SHIFT_MEM;
	localparam int BLK_SIZE_REG = 1 << BLK_SHIFT_REG;

	localparam logic [1:0] FUNC_MEM = 2'd2;
	localparam logic [1:0] FUNC_REG = 2'd1;

	localparam int NUM_SPANS = 8;
	localparam logic [ADDR_W-1:0] SPAN_LO [NUM_SPANS] = '{
		32'h0017_0000, 32'h0010_0000, 32'h0012_0000, 32'h0020_0000,
		32'h0050_0000, 32'h0053_8000, 32'h0054_0000, 32'h0055_c000
	};
	localparam logic [ADDR_W-1:0] SPAN_HI [NUM_SPANS] = '{
		32'h0018_0000, 32'h0012_0000, 32'h0013_0000, 32'h002a_8000,
		32'h0052_0000, 32'h0053_c000, 32'h0055_0000, 32'h0055_e000
	};

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] address;
		logic [CNT_W-1:0]  byte_count;
	} req_t;

	typedef struct packed {
		logic [7:0]          window_low;
		logic [7:0]          window_high;
		logic [1:0]          func_sel;
		logic                block_valid;
		logic [BLKCNT_W-1:0] block_count;
		logic [31:0]         block_arg;
		logic                byte_valid;
		logic [REM_W-1:0]    remainder_bytes;
		logic [31:0]         byte_arg;
		logic                error;
		logic                last;
	} chunk_t;

	// True when the address lies in one of the chip memory ranges.
	function automatic logic in_memory(input logic [ADDR_W-1:0] a);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_SPANS; i++) begin
			if (a >= SPAN_LO[i] && a < SPAN_HI[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

### src/windowed_transfer_splitter.sv
// Windowed transfer splitter top level: splits one transfer request into
// chunk commands. Depends on wts_pkg and windowed_transfer_splitter_assert.svh.
//
//   channel | signals                     | direction | payload
//   req     | req_valid, req_ready, req   | in        | wts_pkg::req_t
//   chunk   | chunk_valid, chunk_ready,   | out       | wts_pkg::chunk_t
//           | chunk                       |           |
//
// A request is taken in, checked, then split into one chunk per cycle
// through the shared chunk unit (min, block split, address update) while
// the chunk output is not stalled; 16 KB on the register function gives
// up to 17 chunks. An error request yields one error chunk, a zero count none.
// Reset clears the sequencer and the output valid; no memory to clear.
// A stalled chunk output holds the chunk unit; req_ready is high only while
// the sequencer waits for a request.
`timescale 1ns / 1ps
`include "windowed_transfer_splitter_assert.svh"

module windowed_transfer_splitter #(
	parameter int MAX_TRANSFER_BYTES = wts_pkg::MAX_TRANSFER_BYTES_DEF,
	parameter int MAX_BLOCK_COUNT = wts_pkg::MAX_BLOCK_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  wts_pkg::req_t   req,
	output logic            chunk_valid,
	input  logic            chunk_ready,
	output wts_pkg::chunk_t chunk
);

	localparam int ADDR_W = wts_pkg::ADDR_W;
	localparam int CNT_W = wts_pkg::CNT_W;
	localparam int WIN_BITS = wts_pkg::WIN_BITS;
	localparam int REM_W = wts_pkg::REM_W;
	localparam int WIN_W = WIN_BITS + 1;
	localparam int XFER_MEM = wts_pkg::BLK_SIZE_MEM * MAX_BLOCK_COUNT;
	localparam int XFER_REG = wts_pkg::BLK_SIZE_REG * MAX_BLOCK_COUNT;
	localparam int XFER_W = $clog2(XFER_MEM + 1);
	localparam int LIM_W = (XFER_W > WIN_W) ? XFER_W : WIN_W;
	localparam logic [ADDR_W:0] ADDR_TOP = {1'b1, {ADDR_W{1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CHECK = 3'b010,
		ST_SPLIT = 3'b100
	} state_t;

	state_t            state_q;
	logic              wr_q;
	logic              func_mem_q;
	logic [ADDR_W-1:0] cur_q;
	logic [CNT_W-1:0]  rem_q;
	logic              chunk_valid_q;
	wts_pkg::chunk_t   chunk_q;

	logic              slot_free;
	logic              req_take;
	logic              bad_size;
	logic              bad_range;
	logic              bad_len;
	logic              req_bad;
	logic [ADDR_W:0]   end_addr;
	logic [WIN_W-1:0]  win_left;
	logic [LIM_W-1:0]  size_cap;
	logic [LIM_W-1:0]  lim_a;
	logic [LIM_W-1:0]  lim_b;
	logic [CNT_W-1:0]  chunk_len;
	logic [CNT_W-1:0]  blocks;
	logic [REM_W-1:0]  rem_bytes;
	logic [CNT_W-1:0]  blk_len;
	logic [WIN_BITS-1:0] byte_addr;
	logic [CNT_W-1:0]  rem_next;
	logic [1:0]        func_sel;
	wts_pkg::chunk_t   chunk_res;
	wts_pkg::chunk_t   error_res;

	assign req_ready = (state_q == ST_IDLE);
	assign req_take = req_valid && req_ready;
	assign slot_free = !chunk_valid_q || chunk_ready;
	assign chunk_valid = chunk_valid_q;
	assign chunk = chunk_q;

	// Request checks on the latched start address and count.
	always_comb begin
		end_addr = {1'b0, cur_q} + (ADDR_W + 1)'(rem_q);
		bad_size = !wr_q && (rem_q[1:0] != 2'b00);
		bad_range = end_addr > ADDR_TOP;
		bad_len = {1'b0, rem_q} > (CNT_W + 1)'(MAX_TRANSFER_BYTES);
		req_bad = bad_size || bad_range || bad_len;
	end

	// Error result: everything zero but the error and last flags.
	always_comb begin
		error_res = '0;
		error_res.error = 1'b1;
		error_res.last = 1'b1;
	end

	// Shared chunk unit: size limit, window cut, block split, arguments.
	always_comb begin
		win_left = (WIN_W)'(1 << WIN_BITS) - {1'b0, cur_q[WIN_BITS-1:0]};
		size_cap = func_mem_q ? (LIM_W)'(XFER_MEM) : (LIM_W)'(XFER_REG);
		lim_a = ((LIM_W)'(rem_q) < size_cap) ? (LIM_W)'(rem_q) : size_cap;
		lim_b = (lim_a > (LIM_W)'(win_left)) ? (LIM_W)'(win_left) : lim_a;
		chunk_len = lim_b[CNT_W-1:0];
		if (func_mem_q) begin
			blocks = chunk_len >> wts_pkg::BLK_SHIFT_MEM;
			rem_bytes = chunk_len[REM_W-1:0];
			func_sel = wts_pkg::FUNC_MEM;
		end else begin
			blocks = chunk_len >> wts_pkg::BLK_SHIFT_REG;
			rem_bytes = {{(REM_W - wts_pkg::BLK_SHIFT_REG){1'b0}},
				chunk_len[wts_pkg::BLK_SHIFT_REG-1:0]};
			func_sel = wts_pkg::FUNC_REG;
		end
		blk_len = chunk_len - (CNT_W)'(rem_bytes);
		byte_addr = cur_q[WIN_BITS-1:0] + (WIN_BITS)'(blk_len);
		rem_next = rem_q - chunk_len;

		chunk_res = '0;
		chunk_res.window_low = cur_q[23:16];
		chunk_res.window_high = cur_q[31:24];
		chunk_res.func_sel = func_sel;
		if (blocks != '0) begin
			chunk_res.block_valid = 1'b1;
			chunk_res.block_count = blocks[wts_pkg::BLKCNT_W-1:0];
			chunk_res.block_arg = {wr_q, 1'b0, func_sel, 1'b1, 1'b1, 1'b0,
				cur_q[WIN_BITS-1:0], blocks[REM_W-1:0]};
		end
		if (rem_bytes != '0) begin
			chunk_res.byte_valid = 1'b1;
			chunk_res.remainder_bytes = rem_bytes;
			chunk_res.byte_arg = {wr_q, 1'b0, func_sel, 1'b0, 1'b1, 1'b0,
				byte_addr, rem_bytes};
		end
		chunk_res.last = (rem_next == '0);
	end

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					priority if (rem_q == '0) begin
						state_q <= ST_IDLE;
					end else if (req_bad) begin
						if (slot_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (slot_free && rem_next == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields and running address and count; no reset needed.
	always_ff @(posedge clk) begin
		if (req_take) begin
			wr_q <= req.command;
			cur_q <= req.address;
			rem_q <= req.byte_count;
		end else if (state_q == ST_CHECK) begin
			func_mem_q <= wts_pkg::in_memory(cur_q);
		end else if (state_q == ST_SPLIT && slot_free) begin
			cur_q <= cur_q + (ADDR_W)'(chunk_len);
			rem_q <= rem_next;
		end
	end

	// Output register flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_valid_q <= 1'b0;
		end else begin
			priority if (state_q == ST_CHECK && rem_q != '0 && req_bad && slot_free) begin
				chunk_valid_q <= 1'b1;
			end else if (state_q == ST_SPLIT && slot_free) begin
				chunk_valid_q <= 1'b1;
			end else if (chunk_ready) begin
				chunk_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		priority if (state_q == ST_CHECK && rem_q != '0 && req_bad && slot_free) begin
			chunk_q <= error_res;
		end else if (state_q == ST_SPLIT && slot_free) begin
			chunk_q <= chunk_res;
		end
	end

	`WTS_ASSERT_SAME(a_err_last, clk, arst_n, chunk_valid && chunk.error, chunk.last, "error result must be last")
	`WTS_ASSERT_SAME(a_err_empty, clk, arst_n, chunk_valid && chunk.error, !chunk.block_valid && !chunk.byte_valid, "error result carries a transfer")
	`WTS_ASSERT_SAME(a_chunk_data, clk, arst_n, chunk_valid && !chunk.error, chunk.block_valid || chunk.byte_valid, "chunk carries no transfer")
	`WTS_ASSERT_SAME(a_split_rem, clk, arst_n, state_q == ST_SPLIT, rem_q != '0, "splitting with nothing left")
	`WTS_ASSERT_NEXT(a_last_idle, clk, arst_n, state_q == ST_SPLIT && slot_free && rem_next == '0, state_q == ST_IDLE, "sequencer did not return after last chunk")

endmodule

### verif/testbench.sv
// Self-checking testbench for the windowed transfer splitter: drives transfer requests,
// predicts the chunk commands each one splits into and checks every chunk in order.
// Depends on wts_pkg and the windowed_transfer_splitter RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_BYTES = 16384;
	localparam int BLOCK_LIMIT = 128;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_REQUESTS = 410;
	localparam int SECOND_DRAIN = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	wts_pkg::req_t req = '0;
	logic chunk_valid;
	logic chunk_ready = 1'b0;
	wts_pkg::chunk_t chunk;

	// Requests waiting to be driven, and chunks expected from requests already taken.
	wts_pkg::req_t pending_reqs [$];
	wts_pkg::chunk_t expected_chunks [$];
	int accepted = 0;
	int checked = 0;
	int failures = 0;
	int directed_count = 0;

	// Chip memory ranges, as half-open intervals.
	logic [31:0] mem_lo [0:7] = '{
		32'h0017_0000, 32'h0010_0000, 32'h0012_0000, 32'h0020_0000,
		32'h0050_0000, 32'h0053_8000, 32'h0054_0000, 32'h0055_c000
	};
	logic [31:0] mem_hi [0:7] = '{
		32'h0018_0000, 32'h0012_0000, 32'h0013_0000, 32'h002a_8000,
		32'h0052_0000, 32'h0053_c000, 32'h0055_0000, 32'h0055_e000
	};

	windowed_transfer_splitter uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.chunk_valid(chunk_valid),
		.chunk_ready(chunk_ready),
		.chunk(chunk)
	);

	always #2 clk = ~clk;

	function automatic logic chip_memory(input logic [31:0] a);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (a >= mem_lo[i] && a < mem_hi[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// Works out the chunk commands for one request and queues them.
	function automatic void split_request(input wts_pkg::req_t r);
		logic [63:0] cur, remaining, piece, boundary, blocks, blk, limit;
		logic [1:0] fsel;
		wts_pkg::chunk_t c;
		if (r.byte_count == '0) begin
			return;
		end
		// Bad read size, running past the top of the address space, or too large.
		if ((!r.command && r.byte_count[1:0] != 2'b00) ||
				({32'd0, r.address} + 64'(r.byte_count) > 64'h1_0000_0000) ||
				r.byte_count > MAX_BYTES) begin
			c = '0;
			c.error = 1'b1;
			c.last = 1'b1;
			expected_chunks.push_back(c);
			return;
		end
		fsel = chip_memory(r.address) ? wts_pkg::FUNC_MEM : wts_pkg::FUNC_REG;
		blk = (fsel == wts_pkg::FUNC_MEM) ? 64'(wts_pkg::BLK_SIZE_MEM) :
			64'(wts_pkg::BLK_SIZE_REG);
		limit = blk * 64'(BLOCK_LIMIT);
		cur = {32'd0, r.address};
		remaining = 64'(r.byte_count);
		while (remaining != 0) begin
			piece = (remaining < limit) ? remaining : limit;
			// Never cross a 64 KB window boundary within one chunk.
			boundary = {cur[63:16], 16'h0000} + 64'h1_0000;
			if (cur + piece > boundary) begin
				piece = boundary - cur;
			end
			c = '0;
			c.window_low = cur[23:16];
			c.window_high = cur[31:24];
			c.func_sel = fsel;
			blocks = piece / blk;
			// Argument layout: write, 0, function, block mode, increment, 0, offset, count.
			if (blocks != 0) begin
				c.block_valid = 1'b1;
				c.block_count = blocks[7:0];
				c.block_arg = {r.command, 1'b0, fsel, 1'b1, 1'b1, 1'b0, cur[15:0],
					blocks[8:0]};
				cur = cur + blocks * blk;
				remaining = remaining - blocks * blk;
				piece = piece - blocks * blk;
			end
			if (piece != 0) begin
				c.byte_valid = 1'b1;
				c.remainder_bytes = piece[8:0];
				c.byte_arg = {r.command, 1'b0, fsel, 1'b0, 1'b1, 1'b0, cur[15:0], piece[8:0]};
				cur = cur + piece;
				remaining = remaining - piece;
			end
			c.last = (remaining == 0);
			expected_chunks.push_back(c);
		end
	endfunction

	function automatic string chunk_text(input wts_pkg::chunk_t c);
		return {$sformatf("win=%h/%h func=%0d blk=%b/%0d/%h ", c.window_high,
			c.window_low, c.func_sel, c.block_valid, c.block_count, c.block_arg),
			$sformatf("byte=%b/%0d/%h err=%b last=%b", c.byte_valid,
			c.remainder_bytes, c.byte_arg, c.error, c.last)};
	endfunction

	function automatic void add_request(input logic cmd, input logic [31:0] addr,
			input logic [14:0] cnt);
		wts_pkg::req_t r;
		r.command = cmd;
		r.address = addr;
		r.byte_count = cnt;
		pending_reqs.push_back(r);
	endfunction

	// Addresses lean toward memory range edges, window edges and the top of the space.
	function automatic logic [31:0] pick_address();
		logic [31:0] a;
		int sel, span, edge_sel;
		sel = $urandom_range(99);
		span = $urandom_range(7);
		edge_sel = $urandom_range(9);
		a = $urandom;
		if (sel < 40) begin
			case (edge_sel)
				0: a = mem_lo[span];
				1: a = mem_hi[span] - 1;
				2: a = mem_hi[span];
				3: a = mem_lo[span] - 1;
				default: a = mem_lo[span] + $urandom_range(mem_hi[span] - mem_lo[span] - 1);
			endcase
		end else if (sel < 60) begin
			a[15:0] = 16'hffff - 16'($urandom_range(1100));
		end else if (sel < 68) begin
			a = 32'hffff_ffff - $urandom_range(20000);
		end
		return a;
	endfunction

	// Counts are mostly small and legal; reads are usually whole words.
	function automatic logic [14:0] pick_count(input logic cmd);
		logic [14:0] n;
		int sel;
		sel = $urandom_range(99);
		if (sel < 3) begin
			n = '0;
		end else if (sel < 8) begin
			n = 15'(MAX_BYTES + 1 + $urandom_range(16382));
		end else if (sel < 14) begin
			n = 15'(MAX_BYTES);
		end else if (sel < 30) begin
			n = 15'($urandom_range(MAX_BYTES));
		end else begin
			n = 15'($urandom_range(2048, 1));
		end
		if (!cmd && $urandom_range(99) < 85) begin
			n[1:0] = 2'b00;
		end
		return n;
	endfunction

	// Request driver: predicts on acceptance, then presents the next request or idles.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				split_request(req);
				accepted = accepted + 1;
			end
			if (!req_valid || req_ready) begin
				if (pending_reqs.size() != 0 &&
						!((accepted == directed_count || accepted == SECOND_DRAIN) &&
						expected_chunks.size() != 0) &&
						((accepted >= 120 && accepted < 200) || $urandom_range(99) >= 25)) begin
					req_valid <= 1'b1;
					req <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Chunk monitor: checks each accepted chunk against the oldest expectation.
	always @(posedge clk) begin
		wts_pkg::chunk_t want;
		logic bad;
		if (!arst_n) begin
			chunk_ready <= 1'b0;
		end else begin
			if (chunk_valid && chunk_ready) begin
				checked = checked + 1;
				if (expected_chunks.size() == 0) begin
					failures = failures + 1;
					if (failures <= REPORT_LIMIT) begin
						$display("unexpected chunk: %s", chunk_text(chunk));
					end
				end else begin
					want = expected_chunks.pop_front();
					bad = (chunk.window_low !== want.window_low) ||
						(chunk.window_high !== want.window_high) ||
						(chunk.func_sel !== want.func_sel) ||
						(chunk.block_valid !== want.block_valid) ||
						(chunk.block_count !== want.block_count) ||
						(chunk.block_arg !== want.block_arg) ||
						(chunk.byte_valid !== want.byte_valid) ||
						(chunk.remainder_bytes !== want.remainder_bytes) ||
						(chunk.byte_arg !== want.byte_arg) ||
						(chunk.error !== want.error) ||
						(chunk.last !== want.last);
					if (bad) begin
						failures = failures + 1;
						if (failures <= REPORT_LIMIT) begin
							$display("chunk mismatch at %0t", $realtime);
							$display("  expected %s", chunk_text(want));
							$display("  actual   %s", chunk_text(chunk));
						end
					end
				end
			end
			chunk_ready <= (checked >= 500 && checked < 900) || ($urandom_range(99) >= 25);
		end
	end

	// Stimulus and end of run.
	initial begin
		logic cmd;
		// Memory function: one chunk of whole blocks, then a window crossing.
		add_request(1'b1, 32'h0017_0000, 15'd16384);
		add_request(1'b0, 32'h0017_ff00, 15'd1024);
		add_request(1'b0, 32'h0020_0000, 15'd16384);
		// Register function: sixteen full chunks, and seventeen when unaligned.
		add_request(1'b1, 32'h0000_1000, 15'd16384);
		add_request(1'b1, 32'h0000_fffd, 15'd16384);
		add_request(1'b1, 32'h1234_5677, 15'd13);
		// Top of the address space: exactly reaching it, and running past it.
		add_request(1'b1, 32'hffff_ffff, 15'd1);
		add_request(1'b1, 32'hffff_ffff, 15'd2);
		add_request(1'b0, 32'hffff_c000, 15'd16384);
		// Bad read size and zero counts.
		add_request(1'b0, 32'h0000_0100, 15'd6);
		add_request(1'b0, 32'h0000_0100, 15'd0);
		add_request(1'b1, 32'hffff_ffff, 15'd0);
		// Oversized counts.
		add_request(1'b1, 32'h0000_0000, 15'd16385);
		add_request(1'b0, 32'h0000_0000, 15'd32764);
		add_request(1'b1, 32'h0000_0000, 15'd32767);
		// Memory range edges.
		add_request(1'b0, 32'h0055_dffc, 15'd4);
		add_request(1'b0, 32'h0055_e000, 15'd4);
		add_request(1'b0, 32'h0010_0000, 15'd512);
		add_request(1'b1, 32'h002a_7fff, 15'd1);
		add_request(1'b1, 32'h0053_bfff, 15'd700);
		add_request(1'b1, 32'h004f_ffff, 15'd3);
		// A tiny write straddling a window boundary.
		add_request(1'b1, 32'h0000_ffff, 15'd2);
		directed_count = pending_reqs.size();
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			cmd = 1'($urandom_range(1));
			add_request(cmd, pick_address(), pick_count(cmd));
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_reqs.size() != 0 || req_valid || expected_chunks.size() != 0) begin
			@(posedge clk);
		end
		repeat (60) @(posedge clk);
		if (expected_chunks.size() != 0) begin
			failures = failures + 1;
			$display("%0d expected chunks never arrived", expected_chunks.size());
		end
		if (failures == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/wts_pkg.sv
src/windowed_transfer_splitter.sv
verif/testbench.sv
